[design/pixel_hsv_adjust_assert.svh]
// ----------------------------------------------------------------------------
// pixel_hsv_adjust assertion macros
// shared property forms for the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef PIXEL_HSV_ADJUST_ASSERT_SVH
`define PIXEL_HSV_ADJUST_ASSERT_SVH

// same-cycle implication
`define HSVA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_hsv_adjust assertion failed");

// next-cycle implication
`define HSVA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_hsv_adjust assertion failed");

`endif

[design/hsva_pkg.sv]
// ----------------------------------------------------------------------------
// hsva_pkg
// types and constants of the hsv adjust pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsva_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int CMAX          = (1 << CHANNEL_BITS) - 1;
    localparam int HUE_FULL      = 23040;
    localparam int HUE_SECTOR    = 3840;
    localparam int ONE_Q16       = 65536;
    localparam int Q_BITS        = 17;                 // q1.16 up to and including 1.0
    localparam int SQ_BITS       = 17;                 // saturation quotient bits
    localparam int HQ_BITS       = 12;                 // hue quotient bits
    localparam int S_NUM_BITS    = CHANNEL_BITS + 16;
    localparam int H_NUM_BITS    = 20;
    localparam int HUE_BITS      = 15;
    localparam int FRAC_BITS     = 12;
    localparam int RECIP15       = 1118482;            // ceil(2^24 / 15)
    localparam int RECIP15_SHIFT = 24;

    typedef enum logic [1:0]
    {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    typedef enum logic [1:0]
    {
        REG_HUE = 2'd0,
        REG_SAT = 2'd1,
        REG_VAL = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed
    {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
    } pixel_out_t;

    typedef struct packed
    {
        logic signed [15:0] hue_delta;
        logic signed [9:0]  saturation_delta;
        logic signed [9:0]  value_delta;
    } cfg_t;

    typedef struct packed
    {
        logic                    grey;
        max_sel_t                sel;
        logic                    h_neg;
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] d;
        logic [S_NUM_BITS-1:0]   s_num;
        logic [H_NUM_BITS-1:0]   h_num;
        logic [Q_BITS-1:0]       v;
    } item_t;

    typedef struct packed
    {
        item_t              item;
        logic [SQ_BITS-1:0] sq;
        logic [HQ_BITS-1:0] hq;
    } div_t;

endpackage

[design/hsva_front.sv]
// ----------------------------------------------------------------------------
// hsva_front
// classifies a pixel: max channel, chroma, value and divider operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsva_front
(
    input  hsva_pkg::pixel_in_t pixel,
    output hsva_pkg::item_t     item
);

    logic [hsva_pkg::CHANNEL_BITS-1:0] r;
    logic [hsva_pkg::CHANNEL_BITS-1:0] g;
    logic [hsva_pkg::CHANNEL_BITS-1:0] b;
    logic [hsva_pkg::CHANNEL_BITS-1:0] mx;
    logic [hsva_pkg::CHANNEL_BITS-1:0] mn;
    logic signed [hsva_pkg::CHANNEL_BITS:0] a;
    logic [hsva_pkg::CHANNEL_BITS-1:0] a_abs;
    hsva_pkg::max_sel_t sel;

    always_comb
    begin
        r = pixel.red_in;
        g = pixel.green_in;
        b = pixel.blue_in;
        mx = r;
        mn = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end

        if (mx == r)
        begin
            sel = hsva_pkg::MAX_RED;
        end
        else if (mx == g)
        begin
            sel = hsva_pkg::MAX_GREEN;
        end
        else
        begin
            sel = hsva_pkg::MAX_BLUE;
        end

        case (sel)
            hsva_pkg::MAX_RED:   a = $signed({1'b0, g}) - $signed({1'b0, b});
            hsva_pkg::MAX_GREEN: a = $signed({1'b0, b}) - $signed({1'b0, r});
            default:             a = $signed({1'b0, r}) - $signed({1'b0, g});
        endcase
        a_abs = a[hsva_pkg::CHANNEL_BITS] ? hsva_pkg::CHANNEL_BITS'(-a)
                                          : hsva_pkg::CHANNEL_BITS'(a);

        item.grey  = (mx == mn);
        item.sel   = sel;
        item.h_neg = a[hsva_pkg::CHANNEL_BITS];
        item.mx    = mx;
        item.d     = mx - mn;
        item.s_num = {item.d, 16'b0};
        item.h_num = hsva_pkg::H_NUM_BITS'(a_abs) * hsva_pkg::H_NUM_BITS'(hsva_pkg::HUE_SECTOR);
        // ceil(mx * 65536 / 255) is 257 * mx, plus one unless black
        item.v     = hsva_pkg::Q_BITS'(mx) * hsva_pkg::Q_BITS'(257)
                   + hsva_pkg::Q_BITS'(mx != '0);
    end

endmodule

[design/hsva_fifo.sv]
// ----------------------------------------------------------------------------
// hsva_fifo
// short request queue between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsva_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsva_pkg::item_t push_item,
    input  logic            pop,
    output hsva_pkg::item_t head,
    output logic            head_valid,
    output logic            full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    hsva_pkg::item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));

endmodule

[design/hsva_back.sv]
// ----------------------------------------------------------------------------
// hsva_back
// divider pipeline, hsv offsets and six-sector conversion back to rgb
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsva_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsva_pkg::cfg_t       cfg,
    input  hsva_pkg::item_t      head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hsva_pkg::pixel_out_t result
);

    localparam int QB = hsva_pkg::Q_BITS;
    localparam int HB = hsva_pkg::HUE_BITS;
    localparam int FB = hsva_pkg::FRAC_BITS;
    localparam int HF = hsva_pkg::HUE_FULL;
    localparam int HS = hsva_pkg::HUE_SECTOR;

    function automatic logic [hsva_pkg::CHANNEL_BITS-1:0] to_channel(logic [QB-1:0] y);
        logic [QB+hsva_pkg::CHANNEL_BITS-1:0] t;
        t = (QB + hsva_pkg::CHANNEL_BITS)'(y) * (QB + hsva_pkg::CHANNEL_BITS)'(hsva_pkg::CMAX);
        return t[QB+hsva_pkg::CHANNEL_BITS-2:16];
    endfunction

    logic adv;

    hsva_pkg::div_t div_reg     [hsva_pkg::SQ_BITS];
    logic           div_vld_reg [hsva_pkg::SQ_BITS];

    // whole pipeline moves while the result slot is free or being taken
    assign adv          = !result_valid || result_ready;
    assign pop          = adv && head_valid;

    genvar j;
    for (j = 0; j < hsva_pkg::SQ_BITS; j++)
    begin : g_div
        localparam int BIT = hsva_pkg::SQ_BITS - 1 - j;
        hsva_pkg::div_t cur;
        hsva_pkg::div_t div_next;
        logic           cur_vld;
        logic [hsva_pkg::S_NUM_BITS-1:0] s_den;
        logic [hsva_pkg::H_NUM_BITS-1:0] h_den;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                cur.item = head;
                cur.sq   = '0;
                cur.hq   = '0;
            end
            assign cur_vld = head_valid;
        end
        else
        begin : g_rest
            assign cur     = div_reg[j-1];
            assign cur_vld = div_vld_reg[j-1];
        end

        // one restoring step per stage for the saturation quotient, and for the hue quotient once BIT is below HQ_BITS
        always_comb
        begin
            div_next = cur;
            s_den = hsva_pkg::S_NUM_BITS'(cur.item.mx) << BIT;
            h_den = hsva_pkg::H_NUM_BITS'(cur.item.d) << BIT;
            if (cur.item.s_num >= s_den)
            begin
                div_next.item.s_num = cur.item.s_num - s_den;
                div_next.sq = cur.sq | (hsva_pkg::SQ_BITS'(1) << BIT);
            end
            if ((BIT < hsva_pkg::HQ_BITS) && (cur.item.h_num >= h_den))
            begin
                div_next.item.h_num = cur.item.h_num - h_den;
                div_next.hq = cur.hq | (hsva_pkg::HQ_BITS'(1) << BIT);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                div_vld_reg[j] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[j] <= div_next;
            end
        end
    end

    // offsets stage
    hsva_pkg::div_t dq;
    logic signed [13:0] q;
    logic signed [15:0] h0;
    logic [QB-1:0]      s0;
    logic signed [18:0] t_hue;
    logic [16:0]        tu;
    logic signed [19:0] s1;
    logic signed [19:0] v1;
    logic [HB-1:0]      a_h_next;
    logic [QB-1:0]      a_s_next;
    logic [QB-1:0]      a_v_next;
    logic [HB-1:0]      a_h_reg;
    logic [QB-1:0]      a_s_reg;
    logic [QB-1:0]      a_v_reg;
    logic               a_vld_reg;

    always_comb
    begin
        dq = div_reg[hsva_pkg::SQ_BITS-1];
        q  = 14'(dq.hq);
        if (dq.item.h_neg)
        begin
            q = -q;
        end
        case (dq.item.sel)
            hsva_pkg::MAX_RED:   h0 = (q < 0) ? 16'(q) + 16'(HF) : 16'(q);
            hsva_pkg::MAX_GREEN: h0 = 16'(q) + 16'(2 * HS);
            hsva_pkg::MAX_BLUE:  h0 = 16'(q) + 16'(4 * HS);
            default:             h0 = '0;
        endcase
        s0 = dq.sq;
        if (dq.item.grey)
        begin
            h0 = '0;
            s0 = '0;
        end

        // bias by two turns so the sum is never negative, then wrap
        t_hue = 19'(h0) + 19'(cfg.hue_delta) + 19'(2 * HF);
        tu    = 17'(t_hue);
        if (tu >= 17'(4 * HF))
        begin
            a_h_next = HB'(tu - 17'(4 * HF));
        end
        else if (tu >= 17'(3 * HF))
        begin
            a_h_next = HB'(tu - 17'(3 * HF));
        end
        else if (tu >= 17'(2 * HF))
        begin
            a_h_next = HB'(tu - 17'(2 * HF));
        end
        else if (tu >= 17'(HF))
        begin
            a_h_next = HB'(tu - 17'(HF));
        end
        else
        begin
            a_h_next = HB'(tu);
        end

        s1 = 20'($signed({1'b0, s0})) + (20'(cfg.saturation_delta) <<< 8);
        v1 = 20'($signed({1'b0, dq.item.v})) + (20'(cfg.value_delta) <<< 8);
        if (s1 < 0)
        begin
            a_s_next = '0;
        end
        else if (s1 > 20'(hsva_pkg::ONE_Q16))
        begin
            a_s_next = QB'(hsva_pkg::ONE_Q16);
        end
        else
        begin
            a_s_next = QB'(s1);
        end
        if (v1 < 0)
        begin
            a_v_next = '0;
        end
        else if (v1 > 20'(hsva_pkg::ONE_Q16))
        begin
            a_v_next = QB'(hsva_pkg::ONE_Q16);
        end
        else
        begin
            a_v_next = QB'(v1);
        end
    end

    // chroma product and sector split
    logic [2*QB-1:0] cv_prod;
    logic [2:0]      b_k_next;
    logic [FB-1:0]   b_f_next;
    logic [QB-1:0]   b_c_next;
    logic [2:0]      b_k_reg;
    logic [FB-1:0]   b_f_reg;
    logic [QB-1:0]   b_c_reg;
    logic [QB-1:0]   b_v_reg;
    logic            b_vld_reg;

    always_comb
    begin
        cv_prod  = (2 * QB)'(a_v_reg) * (2 * QB)'(a_s_reg);
        b_c_next = cv_prod[QB+15:16];
        if (a_h_reg >= HB'(5 * HS))
        begin
            b_k_next = 3'd5;
            b_f_next = FB'(a_h_reg - HB'(5 * HS));
        end
        else if (a_h_reg >= HB'(4 * HS))
        begin
            b_k_next = 3'd4;
            b_f_next = FB'(a_h_reg - HB'(4 * HS));
        end
        else if (a_h_reg >= HB'(3 * HS))
        begin
            b_k_next = 3'd3;
            b_f_next = FB'(a_h_reg - HB'(3 * HS));
        end
        else if (a_h_reg >= HB'(2 * HS))
        begin
            b_k_next = 3'd2;
            b_f_next = FB'(a_h_reg - HB'(2 * HS));
        end
        else if (a_h_reg >= HB'(HS))
        begin
            b_k_next = 3'd1;
            b_f_next = FB'(a_h_reg - HB'(HS));
        end
        else
        begin
            b_k_next = 3'd0;
            b_f_next = FB'(a_h_reg);
        end
    end

    // ramp product
    logic [FB-1:0]    fx;
    logic [QB+FB-1:0] c_p_next;
    logic [QB+FB-1:0] c_p_reg;
    logic [2:0]       c_k_reg;
    logic [QB-1:0]    c_c_reg;
    logic [QB-1:0]    c_v_reg;
    logic             c_vld_reg;

    always_comb
    begin
        fx       = b_k_reg[0] ? FB'(HS) - b_f_reg : b_f_reg;
        c_p_next = (QB + FB)'(b_c_reg) * (QB + FB)'(fx);
    end

    // divide by 3840 as a shift by 8 and a reciprocal of 15
    logic [19:0]   n15;
    logic [40:0]   x_prod;
    logic [QB-1:0] d_x_next;
    logic [QB-1:0] d_m_next;
    logic [QB-1:0] d_x_reg;
    logic [QB-1:0] d_m_reg;
    logic [QB-1:0] d_c_reg;
    logic [2:0]    d_k_reg;
    logic          d_vld_reg;

    always_comb
    begin
        n15      = c_p_reg[27:8];
        x_prod   = 41'(n15) * 41'(hsva_pkg::RECIP15);
        d_x_next = x_prod[hsva_pkg::RECIP15_SHIFT+QB-1:hsva_pkg::RECIP15_SHIFT];
        d_m_next = c_v_reg - c_c_reg;
    end

    // sector assembly and scale to channel range
    logic [QB-1:0]        cr;
    logic [QB-1:0]        cg;
    logic [QB-1:0]        cb;
    hsva_pkg::pixel_out_t result_next;
    hsva_pkg::pixel_out_t result_reg;
    logic                 result_vld_reg;

    always_comb
    begin
        case (d_k_reg)
            3'd0:
            begin
                cr = d_c_reg; cg = d_x_reg; cb = '0;
            end
            3'd1:
            begin
                cr = d_x_reg; cg = d_c_reg; cb = '0;
            end
            3'd2:
            begin
                cr = '0; cg = d_c_reg; cb = d_x_reg;
            end
            3'd3:
            begin
                cr = '0; cg = d_x_reg; cb = d_c_reg;
            end
            3'd4:
            begin
                cr = d_x_reg; cg = '0; cb = d_c_reg;
            end
            default:
            begin
                cr = d_c_reg; cg = '0; cb = d_x_reg;
            end
        endcase
        result_next.red_out   = to_channel(cr + d_m_reg);
        result_next.green_out = to_channel(cg + d_m_reg);
        result_next.blue_out  = to_channel(cb + d_m_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            c_vld_reg      <= 1'b0;
            d_vld_reg      <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg      <= div_vld_reg[hsva_pkg::SQ_BITS-1];
            b_vld_reg      <= a_vld_reg;
            c_vld_reg      <= b_vld_reg;
            d_vld_reg      <= c_vld_reg;
            result_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_h_reg    <= a_h_next;
            a_s_reg    <= a_s_next;
            a_v_reg    <= a_v_next;
            b_k_reg    <= b_k_next;
            b_f_reg    <= b_f_next;
            b_c_reg    <= b_c_next;
            b_v_reg    <= a_v_reg;
            c_p_reg    <= c_p_next;
            c_k_reg    <= b_k_reg;
            c_c_reg    <= b_c_reg;
            c_v_reg    <= b_v_reg;
            d_x_reg    <= d_x_next;
            d_m_reg    <= d_m_next;
            d_c_reg    <= c_c_reg;
            d_k_reg    <= c_k_reg;
            result_reg <= result_next;
        end
    end

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

endmodule

[design/pixel_hsv_adjust.sv]
// ----------------------------------------------------------------------------
// pixel_hsv_adjust
// rgb pixel hue, saturation and value adjustment in fixed point
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pixel_ready is high and returns one adjusted
// pixel per request, in order, once it has passed the queue and every pipeline
// register. The divider pipeline resolves one saturation quotient bit per
// stage over 17 stages, and the hue bits in the later ones. A FIFO_DEPTH-entry
// queue after the classifier absorbs output stalls; pixel_ready drops only when
// that queue is full. Offset registers sit on an APB port at 0x0 (hue), 0x4
// (saturation) and 0x8 (value) and should be written with the pipeline empty.
`timescale 1ns / 1ps

module pixel_hsv_adjust
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  hsva_pkg::pixel_in_t  pixel,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hsva_pkg::pixel_out_t result
);

    hsva_pkg::cfg_t     cfg_reg;
    hsva_pkg::cfg_t     cfg_next;
    hsva_pkg::reg_idx_t reg_idx;
    hsva_pkg::item_t    item;
    hsva_pkg::item_t    head;
    logic               head_valid;
    logic               pop;
    logic               full;
    logic               push;

    assign pready  = 1'b1;
    assign reg_idx = hsva_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_idx)
                hsva_pkg::REG_HUE: cfg_next.hue_delta        = pwdata[15:0];
                hsva_pkg::REG_SAT: cfg_next.saturation_delta = pwdata[9:0];
                hsva_pkg::REG_VAL: cfg_next.value_delta      = pwdata[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
        case (reg_idx)
            hsva_pkg::REG_HUE: prdata = 32'(cfg_reg.hue_delta);
            hsva_pkg::REG_SAT: prdata = 32'(cfg_reg.saturation_delta);
            hsva_pkg::REG_VAL: prdata = 32'(cfg_reg.value_delta);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pixel_ready = !full;
    assign push        = pixel_valid && !full;

    hsva_front u_front
    (
        .pixel (pixel),
        .item  (item)
    );

    hsva_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    hsva_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[design/hsva_checker.sv]
// ----------------------------------------------------------------------------
// hsva_checker
// port-level checks on the pixel and result channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pixel_hsv_adjust_assert.svh"

module hsva_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pixel_valid,
    input logic                 pixel_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input hsva_pkg::pixel_out_t result
);

    logic [5:0] pend_reg;
    logic [5:0] pend_next;

    // requests taken but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (pixel_valid && pixel_ready)
        begin
            pend_next = pend_next + 1'b1;
        end
        if (result_valid && result_ready)
        begin
            pend_next = pend_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `HSVA_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
    `HSVA_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result))
    `HSVA_ASSERT_NOW(a_no_invented, result_valid, pend_reg != '0)
    `HSVA_ASSERT_NOW(a_stall_has_work, !pixel_ready, pend_reg != '0)

endmodule

bind pixel_hsv_adjust hsva_checker u_hsva_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

[tb/pixel_hsv_adjust_tb.sv]
// ----------------------------------------------------------------------------
// pixel_hsv_adjust testbench
// drives pixel requests through the hsv adjust pipeline under random offsets
// and handshake gaps, predicts each adjusted pixel and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_hsv_adjust_tb;

    localparam int LATENCY     = 22;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 pixel_valid;
    logic                 pixel_ready;
    hsva_pkg::pixel_in_t  pixel;
    logic                 result_valid;
    logic                 result_ready;
    hsva_pkg::pixel_out_t result;

    hsva_pkg::cfg_t       offsets;
    hsva_pkg::pixel_in_t  pending_pixels[$];
    hsva_pkg::pixel_out_t expected_pixels[$];
    int                   errors;
    int                   cycles;
    bit                   sender_hold;
    int                   send_gap;
    int                   recv_gap;

    pixel_hsv_adjust i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clamp_unit(int x);
        if (x < 0)
            return 0;
        if (x > hsva_pkg::ONE_Q16)
            return hsva_pkg::ONE_Q16;
        return x;
    endfunction

    function automatic hsva_pkg::pixel_out_t adjust_pixel(hsva_pkg::pixel_in_t p,
                                                          hsva_pkg::cfg_t o);
        int r, g, b, mx, mn, d, h, s, v;
        longint c, x, m, k, f, cr, cg, cb;
        hsva_pkg::pixel_out_t q;
        r = p.red_in;
        g = p.green_in;
        b = p.blue_in;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        h = 0;
        s = 0;
        v = (mx * hsva_pkg::ONE_Q16 + hsva_pkg::CMAX - 1) / hsva_pkg::CMAX;
        if (d > 0)
        begin
            s = (d * hsva_pkg::ONE_Q16) / mx;
            // sv integer division truncates toward zero, as needed here
            if (mx == r)
            begin
                h = ((g - b) * hsva_pkg::HUE_SECTOR) / d;
                if (h < 0)
                    h += hsva_pkg::HUE_FULL;
            end
            else if (mx == g)
                h = 2 * hsva_pkg::HUE_SECTOR + ((b - r) * hsva_pkg::HUE_SECTOR) / d;
            else
                h = 4 * hsva_pkg::HUE_SECTOR + ((r - g) * hsva_pkg::HUE_SECTOR) / d;
        end
        h = (h + int'(o.hue_delta)) % hsva_pkg::HUE_FULL;
        if (h < 0)
            h += hsva_pkg::HUE_FULL;
        s = clamp_unit(s + int'(o.saturation_delta) * 256);
        v = clamp_unit(v + int'(o.value_delta) * 256);
        c = (longint'(v) * s) >>> 16;
        k = h / hsva_pkg::HUE_SECTOR;
        f = h % hsva_pkg::HUE_SECTOR;
        if (k[0])
            x = c * (hsva_pkg::HUE_SECTOR - f) / hsva_pkg::HUE_SECTOR;
        else
            x = c * f / hsva_pkg::HUE_SECTOR;
        m = v - c;
        case (k)
            0: begin cr = c; cg = x; cb = 0; end
            1: begin cr = x; cg = c; cb = 0; end
            2: begin cr = 0; cg = c; cb = x; end
            3: begin cr = 0; cg = x; cb = c; end
            4: begin cr = x; cg = 0; cb = c; end
            default: begin cr = c; cg = 0; cb = x; end
        endcase
        q.red_out   = 8'(((cr + m) * hsva_pkg::CMAX) >>> 16);
        q.green_out = 8'(((cg + m) * hsva_pkg::CMAX) >>> 16);
        q.blue_out  = 8'(((cb + m) * hsva_pkg::CMAX) >>> 16);
        return q;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // driver: one request per handshake, valid held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel       <= '0;
            send_gap    <= 0;
        end
        else
        begin
            if (pixel_valid && !pixel_ready)
            begin
            end
            else
            begin
                if (pixel_valid)
                    expected_pixels.push_back(adjust_pixel(pixel, offsets));
                if (send_gap > 0)
                begin
                    send_gap    <= send_gap - 1;
                    pixel_valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0 && !sender_hold)
                begin
                    pixel       <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                    send_gap    <= pick_gap();
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // monitor and random result stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap     <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result with nothing expected: %h", result);
                    errors++;
                end
                else
                begin
                    hsva_pkg::pixel_out_t e;
                    e = expected_pixels.pop_front();
                    if (result.red_out !== e.red_out)
                    begin
                        $error("red_out expected %0d got %0d", e.red_out, result.red_out);
                        errors++;
                    end
                    if (result.green_out !== e.green_out)
                    begin
                        $error("green_out expected %0d got %0d", e.green_out,
                               result.green_out);
                        errors++;
                    end
                    if (result.blue_out !== e.blue_out)
                    begin
                        $error("blue_out expected %0d got %0d", e.blue_out, result.blue_out);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                recv_gap     <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pixel_hsv_adjust regression: fail");
            $finish;
        end
    end

    task automatic settle();
        while (pending_pixels.size() > 0 || pixel_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(hsva_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hsva_pkg::REG_HUE: offsets.hue_delta        = value[15:0];
            hsva_pkg::REG_SAT: offsets.saturation_delta = value[9:0];
            default:           offsets.value_delta      = value[9:0];
        endcase
    endtask

    task automatic set_offsets(int hue, int sat, int val);
        write_reg(hsva_pkg::REG_HUE, 32'(hue));
        write_reg(hsva_pkg::REG_SAT, 32'(sat));
        write_reg(hsva_pkg::REG_VAL, 32'(val));
    endtask

    function automatic hsva_pkg::pixel_in_t make_pixel(int r, int g, int b);
        hsva_pkg::pixel_in_t p;
        p.red_in   = 8'(r);
        p.green_in = 8'(g);
        p.blue_in  = 8'(b);
        return p;
    endfunction

    function automatic hsva_pkg::pixel_in_t random_pixel();
        hsva_pkg::pixel_in_t p;
        p = hsva_pkg::pixel_in_t'(24'($urandom()));
        case ($urandom_range(0, 5))
            0: p.green_in = p.red_in;  // ties between channels
            1: begin p.green_in = p.red_in; p.blue_in = p.red_in; end
            2: p.blue_in = 8'($urandom_range(0, 1) ? 255 : 0);
            default: ;
        endcase
        return p;
    endfunction

    initial
    begin
        int hue_set[7];
        int sat_set[7];
        int val_set[7];
        hue_set = '{0, 23040, -23040, 7, -1, 32767, -32768};
        sat_set = '{0, 256, -256, 255, -5, 511, -512};
        val_set = '{0, -256, 256, 13, -255, -512, 511};
        errors      = 0;
        cycles      = 0;
        sender_hold = 1'b0;
        offsets     = '0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: greys, primaries, secondaries and extremes at reset offsets
        pending_pixels.push_back(make_pixel(0, 0, 0));
        pending_pixels.push_back(make_pixel(255, 255, 255));
        pending_pixels.push_back(make_pixel(128, 128, 128));
        pending_pixels.push_back(make_pixel(255, 0, 0));
        pending_pixels.push_back(make_pixel(0, 255, 0));
        pending_pixels.push_back(make_pixel(0, 0, 255));
        pending_pixels.push_back(make_pixel(255, 255, 0));
        pending_pixels.push_back(make_pixel(0, 255, 255));
        pending_pixels.push_back(make_pixel(255, 0, 255));
        pending_pixels.push_back(make_pixel(255, 0, 1));
        pending_pixels.push_back(make_pixel(1, 0, 0));
        pending_pixels.push_back(make_pixel(200, 100, 150));
        settle();
        set_offsets(11520, 128, -64);
        for (int i = 0; i < 10; i++)
            pending_pixels.push_back(make_pixel(i * 28, 255 - i * 25, (i * 97) % 256));
        settle();

        // random phases across offset settings, extremes included
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph < 7)
                set_offsets(hue_set[ph], sat_set[ph], val_set[ph]);
            else
                set_offsets($urandom_range(0, 65535) - 32768, $urandom_range(0, 1023) - 512,
                            $urandom_range(0, 1023) - 512);
            for (int i = 0; i < 75; i++)
            begin
                pending_pixels.push_back(random_pixel());
                // once the first requests are out, hold the sender until the pipeline drains
                if (ph == 3 && i == 40)
                begin
                    while (pending_pixels.size() > 0)
                        @(posedge clk);
                    sender_hold = 1'b1;
                    while (expected_pixels.size() > 0 || pixel_valid)
                        @(posedge clk);
                    sender_hold = 1'b0;
                end
            end
            settle();
        end

        if (errors == 0)
            $display("pixel_hsv_adjust regression: pass");
        else
            $display("pixel_hsv_adjust regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/hsva_pkg.sv
design/hsva_front.sv
design/hsva_fifo.sv
design/hsva_back.sv
design/pixel_hsv_adjust.sv
design/hsva_checker.sv
tb/pixel_hsv_adjust_tb.sv
